FILE: src/bhd_pkg.sv
package bhd_pkg;

    // APB register file geometry
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Field widths
    localparam int SAMPLE_W  = 8;
    localparam int FIXED_W   = 12;
    localparam int ROUNDED_W = 8;
    localparam int SIZE_W    = 12;
    localparam int COMP_W    = 3;
    localparam int HSUM_W    = 10;   // horizontal result in quarter units
    localparam int FRAC_W    = 4;    // fraction bits of the 8.4 result

    // Register map: index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_COMPONENTS    = 2'd2
    } t_reg_index;

endpackage

FILE: src/binomial_half_downscale.sv
// Halves an interleaved 8-bit image stream in both directions with a separable
// 1-2-1 binomial filter. The block takes one component sample per cycle with no
// bubbles unless the output stalls: the horizontal sum comes from a tap line of
// recent samples, the vertical sum from a single-port-read, single-port-write
// line store of (MAX_WIDTH/2)*MAX_COMPONENTS entries holding the horizontal
// results of the two previous rows, read on a taken sample and written back as
// the read stage advances. A result passes from the read stage into an output
// register, holds there while stalled; the input stalls only when that register
// and the read stage are both occupied. Writing any register restarts the
// frame; write registers only while no request is in flight. The line store is
// not cleared: every entry is written by one row before the next row reads it.
module binomial_half_downscale #(
    parameter int MAX_WIDTH      = 2048,
    parameter int MAX_HEIGHT     = 2048,
    parameter int MAX_COMPONENTS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bhd_pkg::APB_AW-1:0]    paddr,
    input  logic [bhd_pkg::APB_DW-1:0]    pwdata,
    output logic [bhd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,

    // Sample input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bhd_pkg::SAMPLE_W-1:0]  i_sample,

    // Result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bhd_pkg::FIXED_W-1:0]   o_value_fixed,
    output logic [bhd_pkg::ROUNDED_W-1:0] o_value_rounded,
    output logic                          o_frame_end
);
    import bhd_pkg::*;

    localparam int XW   = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
    localparam int YW   = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int SWW  = (WW > SIZE_W) ? WW : SIZE_W;
    localparam int SHW  = (HW > SIZE_W) ? HW : SIZE_W;
    localparam int NCW  = $clog2(MAX_COMPONENTS + 1);
    localparam int SCW  = (NCW > COMP_W) ? NCW : COMP_W;
    localparam int CCW  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int TAPS = 2 * MAX_COMPONENTS;
    localparam int TIW  = $clog2(TAPS);
    localparam int LINE_DEPTH = (MAX_WIDTH / 2) * MAX_COMPONENTS;
    localparam int AW   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int IXW  = XW + NCW;

    // Configuration registers
    logic [SIZE_W-1:0] r_source_width;
    logic [SIZE_W-1:0] r_source_height;
    logic [COMP_W-1:0] r_components;
    logic              cfg_write;
    t_reg_index        cfg_index;

    // Frame position
    logic [XW-1:0]  r_x, n_x;
    logic [YW-1:0]  r_y, n_y;
    logic [CCW-1:0] r_c, n_c;

    // Recent samples, newest at tap 0
    logic [SAMPLE_W-1:0] r_tap [TAPS];

    // Line store: {older row, newer row} horizontal results
    logic [2*HSUM_W-1:0] r_line_mem [LINE_DEPTH];
    logic [2*HSUM_W-1:0] r_line_rdata;

    // Read stage
    logic              r_s1_valid;
    logic              r_s1_write;
    logic              r_s1_produce;
    logic              r_s1_ypair;
    logic              r_s1_last;
    logic [HSUM_W-1:0] r_s1_hv;
    logic [AW-1:0]     r_s1_addr;

    // Output register
    logic                 r_out_valid;
    logic [FIXED_W-1:0]   r_out_fixed;
    logic [ROUNDED_W-1:0] r_out_rounded;
    logic                 r_out_last;

    // Effective sizes
    logic [SWW-1:0] w_ext;
    logic [SHW-1:0] h_ext;
    logic [SCW-1:0] nc_ext;
    logic [WW-1:0]  w_eff, w_m1, w_m2, x_ext;
    logic [HW-1:0]  h_eff, h_m1, h_m2, y_ext;
    logic [NCW-1:0] nc_eff, nc_m1;
    logic [NCW:0]   nc2_m1;

    // Per-sample decode
    logic              in_accept;
    logic              s1_adv;
    logic              out_free;
    logic              w_odd, h_odd;
    logic              x_event, x_pair, x_last, x_odd_end;
    logic              y_event, y_pair, y_last;
    logic              c_last;
    logic [SAMPLE_W-1:0] p1, p2;
    logic [HSUM_W-1:0] hv;
    logic [XW-1:0]     k;
    logic [IXW-1:0]    addr_full;
    logic [AW-1:0]     addr;

    // Vertical stage
    logic [HSUM_W-1:0]  older, newer;
    logic [FIXED_W-1:0] v;
    logic [FIXED_W-1:0] v_round;

    // APB access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = t_reg_index'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width  <= SIZE_W'(2);
            r_source_height <= SIZE_W'(2);
            r_components    <= COMP_W'(1);
        end else if (cfg_write) begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  r_source_width  <= pwdata[SIZE_W-1:0];
                REG_SOURCE_HEIGHT: r_source_height <= pwdata[SIZE_W-1:0];
                REG_COMPONENTS:    r_components    <= pwdata[COMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_SOURCE_WIDTH:  prdata = APB_DW'(r_source_width);
            REG_SOURCE_HEIGHT: prdata = APB_DW'(r_source_height);
            REG_COMPONENTS:    prdata = APB_DW'(r_components);
            default:           prdata = '0;
        endcase
    end

    // Clamp sizes into the supported range
    assign w_ext  = SWW'(r_source_width);
    assign h_ext  = SHW'(r_source_height);
    assign nc_ext = SCW'(r_components);

    always_comb begin
        if (w_ext < SWW'(2))              w_eff = WW'(2);
        else if (w_ext > SWW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
        else                              w_eff = w_ext[WW-1:0];

        if (h_ext < SHW'(2))               h_eff = HW'(2);
        else if (h_ext > SHW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
        else                               h_eff = h_ext[HW-1:0];

        if (nc_ext < SCW'(1))                   nc_eff = NCW'(1);
        else if (nc_ext > SCW'(MAX_COMPONENTS)) nc_eff = NCW'(MAX_COMPONENTS);
        else                                    nc_eff = nc_ext[NCW-1:0];
    end

    assign w_m1   = w_eff - WW'(1);
    assign w_m2   = w_eff - WW'(2);
    assign h_m1   = h_eff - HW'(1);
    assign h_m2   = h_eff - HW'(2);
    assign nc_m1  = nc_eff - NCW'(1);
    assign nc2_m1 = {nc_eff, 1'b0} - (NCW+1)'(1);
    assign w_odd  = w_eff[0];
    assign h_odd  = h_eff[0];
    assign x_ext  = WW'(r_x);
    assign y_ext  = HW'(r_y);

    // Axis decode: which positions complete an output, and which average a pair
    assign x_last    = (x_ext == w_m1);
    assign y_last    = (y_ext == h_m1);
    assign c_last    = (NCW'(r_c) == nc_m1);
    assign x_odd_end = w_odd && x_last;
    assign x_event   = x_odd_end || (r_x[0] && !(w_odd && x_ext == w_m2));
    assign x_pair    = (x_ext == WW'(1)) || x_odd_end;
    assign y_event   = (h_odd && y_last) || (r_y[0] && !(h_odd && y_ext == h_m2));
    assign y_pair    = (y_ext == HW'(1)) || (h_odd && y_last);

    // Horizontal 1-2-1 sum in quarter units
    assign p1 = r_tap[TIW'(nc_m1)];
    assign p2 = r_tap[TIW'(nc2_m1)];

    always_comb begin
        if (x_pair) hv = HSUM_W'({(HSUM_W-1)'(p1) + (HSUM_W-1)'(i_sample), 1'b0});
        else        hv = HSUM_W'(p2) + HSUM_W'({p1, 1'b0}) + HSUM_W'(i_sample);
    end

    // Line store address: output column times components plus component
    assign k         = x_odd_end ? (r_x >> 1) - XW'(1) : (r_x >> 1);
    assign addr_full = IXW'(k) * IXW'(nc_eff) + IXW'(r_c);
    assign addr      = addr_full[AW-1:0];

    // Handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && (!r_s1_produce || out_free);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Advance frame position; any register write restarts the frame
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_c = r_c;
        if (in_accept) begin
            if (c_last) begin
                n_c = '0;
                if (x_last) begin
                    n_x = '0;
                    n_y = y_last ? '0 : r_y + YW'(1);
                end else begin
                    n_x = r_x + XW'(1);
                end
            end else begin
                n_c = r_c + CCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_write) begin
            r_x <= '0;
            r_y <= '0;
            r_c <= '0;
        end else begin
            r_x <= n_x;
            r_y <= n_y;
            r_c <= n_c;
        end
    end

    // Shift the tap line on every accepted sample
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_tap[0] <= i_sample;
            for (int i = 1; i < TAPS; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    // Line store: read on x_event accepts, write back when the read stage advances.
    // Reuse of an entry is a full output row apart, so reads never overtake.
    always_ff @(posedge i_clk) begin
        if (in_accept && x_event) begin
            r_line_rdata <= r_line_mem[addr];
        end
        if (s1_adv && r_s1_write) begin
            r_line_mem[r_s1_addr] <= {r_line_rdata[HSUM_W-1:0], r_s1_hv};
        end
    end

    // Read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Read stage payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_write   <= x_event;
            r_s1_produce <= x_event && y_event;
            r_s1_ypair   <= y_pair;
            r_s1_last    <= x_last && y_last && c_last;
            r_s1_hv      <= hv;
            r_s1_addr    <= addr;
        end
    end

    // Vertical 1-2-1 sum in sixteenth units
    assign older   = r_line_rdata[2*HSUM_W-1:HSUM_W];
    assign newer   = r_line_rdata[HSUM_W-1:0];
    assign v       = r_s1_ypair
                   ? FIXED_W'({FIXED_W'(newer) + FIXED_W'(r_s1_hv), 1'b0})
                   : FIXED_W'(older) + FIXED_W'({newer, 1'b0}) + FIXED_W'(r_s1_hv);
    assign v_round = v + FIXED_W'(8);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_produce) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_produce) begin
            r_out_fixed   <= v;
            r_out_rounded <= v_round[FIXED_W-1:FRAC_W];
            r_out_last    <= r_s1_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_value_fixed   = r_out_fixed;
    assign o_value_rounded = r_out_rounded;
    assign o_frame_end     = r_out_last;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import bhd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int SIZE_CEILING   = 2048;
    localparam int MAX_COMP       = 4;
    localparam int LINE_ENTRIES   = (SIZE_CEILING / 2) * MAX_COMP;
    localparam int RANDOM_TARGET  = 300;

    typedef struct packed {
        logic [FIXED_W-1:0]   value_fixed;
        logic [ROUNDED_W-1:0] value_rounded;
        logic                 frame_end;
    } t_result;

    typedef struct packed {
        logic [SAMPLE_W-1:0] component;
        logic                typed_want;
        t_result             want;
    } t_directed_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [SAMPLE_W-1:0]  i_sample;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [FIXED_W-1:0]   o_value_fixed;
    logic [ROUNDED_W-1:0] o_value_rounded;
    logic                 o_frame_end;

    binomial_half_downscale i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_sample        (i_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_value_fixed   (o_value_fixed),
        .o_value_rounded (o_value_rounded),
        .o_frame_end     (o_frame_end)
    );

    // Free-running clock, 2 ns period
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Downscaler model state: registers, raster position, taps, line store
    logic [SIZE_W-1:0] cfg_width;
    logic [SIZE_W-1:0] cfg_height;
    logic [COMP_W-1:0] cfg_components;
    int                col_pos;
    int                row_pos;
    int                comp_pos;
    int                tap_last [MAX_COMP];
    int                tap_prev [MAX_COMP];
    int                line_older [LINE_ENTRIES];
    int                line_newer [LINE_ENTRIES];

    t_result pending_results [$];
    int      mismatches;
    int      quiet_cycles;

    function automatic int effective_size(int raw);
        if (raw < 2) return 2;
        if (raw > SIZE_CEILING) return SIZE_CEILING;
        return raw;
    endfunction

    function automatic int effective_components(int raw);
        if (raw < 1) return 1;
        if (raw > MAX_COMP) return MAX_COMP;
        return raw;
    endfunction

    // Source position p of an axis of size n closes an output position
    function automatic bit axis_completes(int p, int n);
        bit odd;
        odd = (n % 2) == 1;
        if (odd && p == n - 1) return 1'b1;
        return (p % 2) == 1 && !(odd && p == n - 2);
    endfunction

    // Two-tap average: first output, or last output of an odd size
    function automatic bit axis_two_tap(int p, int n);
        return p == 1 || ((n % 2) == 1 && p == n - 1);
    endfunction

    function automatic void reset_predictor();
        cfg_width      = SIZE_W'(2);
        cfg_height     = SIZE_W'(2);
        cfg_components = COMP_W'(1);
        col_pos        = 0;
        row_pos        = 0;
        comp_pos       = 0;
        for (int i = 0; i < MAX_COMP; i++) begin
            tap_last[i] = 0;
            tap_prev[i] = 0;
        end
        for (int i = 0; i < LINE_ENTRIES; i++) begin
            line_older[i] = 0;
            line_newer[i] = 0;
        end
    endfunction

    // Register write: update the setting and restart the frame
    function automatic void apply_register(t_reg_index idx, logic [APB_DW-1:0] value);
        case (idx)
            REG_SOURCE_WIDTH: begin
                cfg_width = value[SIZE_W-1:0];
            end
            REG_SOURCE_HEIGHT: begin
                cfg_height = value[SIZE_W-1:0];
            end
            REG_COMPONENTS: begin
                cfg_components = value[COMP_W-1:0];
            end
            default: begin
                return;
            end
        endcase
        col_pos  = 0;
        row_pos  = 0;
        comp_pos = 0;
    endfunction

    // Advance the downscaler by one component; return 1 when it yields a result
    function automatic bit downscale_step(input int cur, output t_result res);
        int w;
        int h;
        int nc;
        int c;
        int p1;
        int p2;
        int hv;
        int k;
        int idx;
        int older;
        int newer;
        int v;
        int rounded;
        bit produced;
        w        = effective_size(int'(cfg_width));
        h        = effective_size(int'(cfg_height));
        nc       = effective_components(int'(cfg_components));
        c        = (comp_pos >= nc) ? 0 : comp_pos;
        p1       = tap_last[c];
        p2       = tap_prev[c];
        produced = 1'b0;
        res      = '0;

        // Horizontal filter, then vertical filter against the two stored rows
        if (axis_completes(col_pos, w)) begin
            if (axis_two_tap(col_pos, w)) hv = 2 * (p1 + cur);
            else hv = p2 + 2 * p1 + cur;
            if ((w % 2) == 1 && col_pos == w - 1) k = w / 2 - 1;
            else k = col_pos / 2;
            idx   = k * nc + c;
            older = line_older[idx];
            newer = line_newer[idx];
            if (axis_completes(row_pos, h)) begin
                if (axis_two_tap(row_pos, h)) v = 2 * (newer + hv);
                else v = older + 2 * newer + hv;
                v                 = v % 4096;
                rounded           = ((v + 8) / 16) % 256;
                res.value_fixed   = v[FIXED_W-1:0];
                res.value_rounded = rounded[ROUNDED_W-1:0];
                res.frame_end     = col_pos == w - 1 && row_pos == h - 1 && c == nc - 1;
                produced          = 1'b1;
            end
            line_older[idx] = newer;
            line_newer[idx] = hv % 1024;
        end

        // Shift taps and advance the raster position
        tap_prev[c] = p1;
        tap_last[c] = cur;
        c++;
        if (c >= nc) begin
            c = 0;
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h) row_pos = 0;
            end
        end
        comp_pos = c;
        return produced;
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int random_component();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return 255;
        return $urandom_range(0, 255);
    endfunction

    // Write a register and read it back
    task automatic program_register(t_reg_index idx, int value);
        logic [APB_DW-1:0] wdata;
        logic [APB_DW-1:0] want;
        wdata = APB_DW'(value);
        want  = (idx == REG_COMPONENTS) ? (wdata & ((1 << COMP_W) - 1))
                                        : (wdata & ((1 << SIZE_W) - 1));
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        apply_register(idx, wdata);

        // Read back in the next transfer
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== want)
            flag_mismatch($sformatf("register %s read: expected 0x%0h, got 0x%0h",
                                    idx.name(), want, prdata));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one request after an optional gap; return at the negedge after acceptance
    task automatic send_component(int value, int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= value[SAMPLE_W-1:0];
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every expected result, then let the pipe empty
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(int w, int h, int c, int count, bit with_gaps);
        t_result res;
        int      value;
        program_register(REG_SOURCE_WIDTH, w);
        program_register(REG_SOURCE_HEIGHT, h);
        program_register(REG_COMPONENTS, c);
        for (int i = 0; i < count; i++) begin
            value = random_component();
            send_component(value, with_gaps ? pick_gap() : 0);
            if (downscale_step(value, res)) pending_results.push_back(res);
        end
        drain_pipe();
    endtask

    // Reset settings (2 x 2, one component): each group of four is one frame;
    // the all-zero and all-full frames carry their result, the rest use the predictor
    t_directed_row directed_rows [24] = '{
        '{8'd0,   1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd0,   1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd0,   1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd0,   1'b1, '{12'd0,    8'd0,   1'b1}},
        '{8'd255, 1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd255, 1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd255, 1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd255, 1'b1, '{12'd4080, 8'd255, 1'b1}},
        '{8'd1,   1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd1,   1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd0,   1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd0,   1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd1,   1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd0,   1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd0,   1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd0,   1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd0,   1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd0,   1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd1,   1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd2,   1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd128, 1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd127, 1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd1,   1'b0, '{12'd0,    8'd0,   1'b0}},
        '{8'd0,   1'b0, '{12'd0,    8'd0,   1'b0}}
    };

    // Main sequence: reset, directed rows, directed settings, random settings
    initial begin
        t_result res;
        int      w;
        int      h;
        int      c;
        int      frame_len;
        int      count;
        int      random_items;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_in_valid   = 1'b0;
        i_sample     = '0;
        mismatches   = 0;
        random_items = 0;
        reset_predictor();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            send_component(int'(directed_rows[i].component), pick_gap());
            if (downscale_step(int'(directed_rows[i].component), res))
                pending_results.push_back(directed_rows[i].typed_want ? directed_rows[i].want
                                                                      : res);
        end
        drain_pipe();

        // Odd sizes of three, odd five with three components, sizes and component
        // count below range, restart in mid frame, two frames at four components,
        // the start of the widest and tallest frames with clamped settings
        run_phase(3, 3, 1, 18, 1'b1);
        run_phase(5, 5, 3, 150, 1'b0);
        run_phase(0, 1, 0, 12, 1'b1);
        run_phase(4, 6, 2, 30, 1'b1);
        run_phase(4, 6, 2, 48, 1'b1);
        run_phase(7, 4, 4, 224, 1'b0);
        run_phase(6, 5, 7, 240, 1'b1);
        run_phase(4095, 2, 7, 48, 1'b1);
        run_phase(2048, 2, 1, 40, 1'b0);
        run_phase(2, 4095, 1, 64, 1'b1);
        run_phase(3, 2048, 1, 60, 1'b1);

        // Random settings, mostly whole frames with some cut short
        while (random_items < RANDOM_TARGET) begin
            case ($urandom_range(0, 19))
                0, 1:    w = $urandom_range(0, 1);
                2:       w = $urandom_range(10, 24);
                default: w = $urandom_range(2, 9);
            endcase
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 7);
            c = $urandom_range(0, 7);
            frame_len = effective_size(w) * effective_size(h) * effective_components(c);
            if ($urandom_range(0, 3) == 0) count = $urandom_range(1, frame_len - 1);
            else if (frame_len > 300) count = frame_len;
            else count = frame_len * $urandom_range(1, 2);
            if (count > RANDOM_TARGET - random_items) count = RANDOM_TARGET - random_items;
            run_phase(w, h, c, count, $urandom_range(0, 3) != 0);
            random_items += count;
        end

        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("binomial_half_downscale regression: pass");
        end else begin
            $display("binomial_half_downscale regression: fail");
        end
        $finish;
    end

    // Output stall: runs of ready, occasionally long, between random stalls
    initial begin
        int run;
        i_out_stall = 1'b0;
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 12);
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            repeat (run - 1) @(negedge i_clk);
            run = pick_gap();
            if (run > 0) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (run - 1) @(negedge i_clk);
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got = {o_value_fixed, o_value_rounded, o_frame_end};
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result: fixed=%0d rounded=%0d end=%0d",
                                        got.value_fixed, got.value_rounded, got.frame_end));
            end else begin
                want = pending_results.pop_front();
                if (got !== want)
                    flag_mismatch($sformatf({"result mismatch: expected fixed=%0d rounded=%0d ",
                                             "end=%0d, got fixed=%0d rounded=%0d end=%0d"},
                                            want.value_fixed, want.value_rounded,
                                            want.frame_end, got.value_fixed,
                                            got.value_rounded, got.frame_end));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("binomial_half_downscale regression: fail");
            $finish;
        end
    end

endmodule

FILE: files.f
src/bhd_pkg.sv
src/binomial_half_downscale.sv
sim/testbench.sv
